// File: hdl/sawfs_pkg.sv
// ----------------------------------------------------------------------------
// sawfs_pkg
// Shared types, codes and the checksum chain step for the stop-and-wait
// frame sender.
// ----------------------------------------------------------------------------
`default_nettype none

package sawfs_pkg;

    localparam int unsigned MaxPayload = 509;

    localparam logic [7:0] TYPE_ACK      = 8'h03;
    localparam logic [7:0] TYPE_LAST     = 8'h18;
    localparam logic [7:0] TYPE_NOT_LAST = 8'h08;

    localparam logic [15:0] TIMEOUT_RESET = 16'd500;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_DATA  = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_ACK   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        EV_NONE   = 3'd0,
        EV_READY  = 3'd1,
        EV_RETX   = 3'd2,
        EV_DONE   = 3'd3,
        EV_REJECT = 3'd4
    } event_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [8:0] packet_length;
        logic       is_final;
        logic [7:0] data_byte;
        logic [7:0] ack_sum;
        logic [7:0] ack_type;
        logic [7:0] ack_order;
    } item_t;

    typedef struct packed {
        event_t     event_res;
        logic [7:0] checksum;
        logic [7:0] frame_type;
        logic [7:0] sequence_res;
        logic [7:0] length_byte;
    } result_t;

    // One step of the signed-byte checksum chain: s = b + r, m = s rem 255
    // (truncated toward zero), new r = (b + m) mod 256.
    function automatic logic [7:0] chain_step(input logic [7:0] r, input logic [7:0] b);
        logic signed [9:0] s;
        logic signed [9:0] m;
        logic [9:0]        t;
        s = $signed({{2{b[7]}}, b}) + $signed({{2{r[7]}}, r});
        if (s == -10'sd255)
            m = 10'sd0;
        else if (s == -10'sd256)
            m = -10'sd1;
        else
            m = s;
        t = {{2{b[7]}}, b} + m;
        return t[7:0];
    endfunction

endpackage

`default_nettype wire

// File: hdl/sawfs_core.sv
// ----------------------------------------------------------------------------
// sawfs_core
// Protocol state of the sender: phase, sequence, checksum chain, payload
// count, acknowledgement timer and timeout register. Gives the result of
// one request combinationally and updates state when the request is stepped.
// ----------------------------------------------------------------------------
`default_nettype none

module sawfs_core (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    step,
    input  sawfs_pkg::item_t       item,
    input  wire                    cfg_wr_en,
    input  wire  [15:0]            cfg_wr_data,
    output sawfs_pkg::result_t     result
);
    import sawfs_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_LOAD = 2'd1,
        PH_WAIT = 2'd2
    } phase_t;

    phase_t      phase_reg,         phase_next;
    logic [7:0]  seq_count_reg,     seq_count_next;
    logic [7:0]  running_sum_reg,   running_sum_next;
    logic [8:0]  bytes_left_reg,    bytes_left_next;
    logic [15:0] wait_timer_reg,    wait_timer_next;
    logic        final_flag_reg,    final_flag_next;
    logic [7:0]  held_length_reg,   held_length_next;
    logic [7:0]  held_checksum_reg, held_checksum_next;
    logic [15:0] timeout_ticks_reg;

    logic        bad_start;
    logic [7:0]  sum_type;
    logic [7:0]  sum_seq;
    logic [7:0]  sum_len;
    logic [7:0]  sum_data;
    logic [8:0]  left_dec;
    logic [15:0] timer_inc;
    logic [7:0]  ack_chain;
    logic        ack_ok;
    event_t      ev;

    assign bad_start = (phase_reg != PH_IDLE)
                    || ({4'd0, item.packet_length} > 13'(MaxPayload))
                    || (!item.is_final && ({4'd0, item.packet_length} != 13'(MaxPayload)));
    assign sum_type  = item.is_final ? TYPE_LAST : TYPE_NOT_LAST;
    assign sum_seq   = chain_step(sum_type, seq_count_reg);
    assign sum_len   = chain_step(sum_seq, item.packet_length[7:0]);
    assign sum_data  = chain_step(running_sum_reg, item.data_byte);
    assign left_dec  = bytes_left_reg - 9'd1;
    assign timer_inc = wait_timer_reg + 16'd1;
    assign ack_chain = chain_step(chain_step(item.ack_sum, item.ack_type), item.ack_order);
    assign ack_ok    = (ack_chain == 8'hFF) && (item.ack_type == TYPE_ACK)
                    && (item.ack_order == seq_count_reg);

    always_comb
    begin
        phase_next         = phase_reg;
        seq_count_next     = seq_count_reg;
        running_sum_next   = running_sum_reg;
        bytes_left_next    = bytes_left_reg;
        wait_timer_next    = wait_timer_reg;
        final_flag_next    = final_flag_reg;
        held_length_next   = held_length_reg;
        held_checksum_next = held_checksum_reg;
        ev                 = EV_NONE;

        case (item.cmd)
            CMD_START:
            begin
                if (bad_start)
                begin
                    ev = EV_REJECT;
                end
                else
                begin
                    final_flag_next  = item.is_final;
                    held_length_next = item.is_final ? item.packet_length[7:0] : 8'd0;
                    running_sum_next = item.is_final ? sum_len : sum_seq;
                    bytes_left_next  = item.packet_length;
                    if (item.packet_length == 9'd0)
                    begin
                        held_checksum_next = ~running_sum_next;
                        phase_next         = PH_WAIT;
                        wait_timer_next    = 16'd0;
                        ev                 = EV_READY;
                    end
                    else
                    begin
                        phase_next = PH_LOAD;
                    end
                end
            end
            CMD_DATA:
            begin
                if (phase_reg == PH_LOAD)
                begin
                    running_sum_next = sum_data;
                    bytes_left_next  = left_dec;
                    if (left_dec == 9'd0)
                    begin
                        held_checksum_next = ~sum_data;
                        phase_next         = PH_WAIT;
                        wait_timer_next    = 16'd0;
                        ev                 = EV_READY;
                    end
                end
            end
            CMD_TICK:
            begin
                if (phase_reg == PH_WAIT)
                begin
                    wait_timer_next = timer_inc;
                    if (timer_inc >= timeout_ticks_reg)
                    begin
                        wait_timer_next = 16'd0;
                        ev              = EV_RETX;
                    end
                end
            end
            default:
            begin
                if (phase_reg == PH_WAIT)
                begin
                    wait_timer_next = 16'd0;
                    if (ack_ok)
                    begin
                        seq_count_next = seq_count_reg + 8'd1;
                        phase_next     = PH_IDLE;
                        ev             = EV_DONE;
                    end
                    else
                    begin
                        ev = EV_RETX;
                    end
                end
            end
        endcase
    end

    // Frame fields: sequence before any advance, the rest as left by this request.
    always_comb
    begin
        result.event_res = ev;
        if (ev == EV_NONE || ev == EV_REJECT)
        begin
            result.checksum     = 8'd0;
            result.frame_type   = 8'd0;
            result.sequence_res = 8'd0;
            result.length_byte  = 8'd0;
        end
        else
        begin
            result.checksum     = held_checksum_next;
            result.frame_type   = final_flag_next ? TYPE_LAST : TYPE_NOT_LAST;
            result.sequence_res = seq_count_reg;
            result.length_byte  = held_length_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            seq_count_reg     <= 8'd0;
            running_sum_reg   <= 8'd0;
            bytes_left_reg    <= 9'd0;
            wait_timer_reg    <= 16'd0;
            final_flag_reg    <= 1'b0;
            held_length_reg   <= 8'd0;
            held_checksum_reg <= 8'd0;
            timeout_ticks_reg <= TIMEOUT_RESET;
        end
        else
        begin
            if (cfg_wr_en)
                timeout_ticks_reg <= cfg_wr_data;
            if (step)
            begin
                phase_reg         <= phase_next;
                seq_count_reg     <= seq_count_next;
                running_sum_reg   <= running_sum_next;
                bytes_left_reg    <= bytes_left_next;
                wait_timer_reg    <= wait_timer_next;
                final_flag_reg    <= final_flag_next;
                held_length_reg   <= held_length_next;
                held_checksum_reg <= held_checksum_next;
            end
        end
    end

endmodule

`default_nettype wire

// File: hdl/stop_and_wait_frame_sender.sv
// Path: a request accepted is held in the input register, then its result in
// the result register; one result per request.
// Throughput: one request per cycle unless output stalls; the checksum chain
// step and control update fit between the input and result registers.
// Reset: rst_n clears all protocol state, the timeout to 500 ticks, and both
// register stages to empty.
// ----------------------------------------------------------------------------
// stop_and_wait_frame_sender
// Stop-and-wait ARQ sender with streaming request and result channels and a
// write-only timeout register.
// ----------------------------------------------------------------------------
`default_nettype none

module stop_and_wait_frame_sender (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // packet_length[8:0], data_byte[16:9], ack_sum[24:17], ack_type[32:25],
    // ack_order[40:33], zero [47:41]
    input  wire  [47:0] s_axis_tdata,
    // cmd[1:0]
    input  wire  [1:0]  s_axis_tuser,
    // is_final
    input  wire         s_axis_tlast,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // checksum[7:0], frame_type[15:8], sequence_res[23:16], length_byte[31:24]
    output logic [31:0] m_axis_tdata,
    // event_res[2:0]
    output logic [2:0]  m_axis_tuser,
    input  wire         cfg_wr_en,
    input  wire  [15:0] cfg_wr_data
);
    import sawfs_pkg::*;

    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_res_reg;
    result_t core_res;
    logic    advance;

    // Move the held request into the result register when that is free.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    sawfs_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .item        (in_item_reg),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .result      (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_item_reg.cmd           <= cmd_t'(s_axis_tuser);
            in_item_reg.packet_length <= s_axis_tdata[8:0];
            in_item_reg.is_final      <= s_axis_tlast;
            in_item_reg.data_byte     <= s_axis_tdata[16:9];
            in_item_reg.ack_sum       <= s_axis_tdata[24:17];
            in_item_reg.ack_type      <= s_axis_tdata[32:25];
            in_item_reg.ack_order     <= s_axis_tdata[40:33];
        end
        if (advance)
            out_res_reg <= core_res;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_res_reg.event_res;
    assign m_axis_tdata  = {out_res_reg.length_byte, out_res_reg.sequence_res,
                            out_res_reg.frame_type, out_res_reg.checksum};

endmodule

`default_nettype wire
